[sv/ese_pkg.sv]
// Shared types and constants for the envelope sequence encoder.
// Holds the item structs, the command and event formats, and the bytecode codes.
// No dependencies.
package ese_pkg;

  localparam int MAX_BYTES   = 64;
  localparam int RESULT_CAP  = 64;
  localparam int CNT_W       = $clog2(RESULT_CAP + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [8:0] MAX_POS       = 9'(MAX_BYTES);
  localparam logic [8:0] POINTER_START = 9'd1;
  localparam logic [8:0] POINTER_TOP   = 9'd511;
  localparam logic [15:0] FRAMES_TOP   = 16'hFFFF;

  localparam logic [2:0] KIND_BEGIN   = 3'd0;
  localparam logic [2:0] KIND_VALUE   = 3'd1;
  localparam logic [2:0] KIND_HOLD    = 3'd2;
  localparam logic [2:0] KIND_SWEEP   = 3'd3;
  localparam logic [2:0] KIND_LOOP    = 3'd4;
  localparam logic [2:0] KIND_RELEASE = 3'd5;
  localparam logic [2:0] KIND_FINISH  = 3'd6;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_LOOP_END = 2'd2;

  localparam logic [7:0] BYTE_VALUE_MASK = 8'h7F;
  localparam logic [7:0] BYTE_HOLD       = 8'h80;
  localparam logic [7:0] BYTE_HOLD_FULL  = 8'h8F;
  localparam logic [7:0] BYTE_JUMP       = 8'hC0;
  localparam logic [7:0] BYTE_HEADER_BEGIN = 8'h00;

  typedef enum logic [2:0] {
    OP_BEGIN,
    OP_VALUE,
    OP_HOLD,
    OP_SWEEP,
    OP_LOOP,
    OP_RELEASE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [7:0] level;
    logic [7:0]        hold_frames;
    logic signed [7:0] sweep_end;
    logic [7:0]        sweep_steps;
  } in_item_t;

  typedef struct packed {
    logic [7:0] position;
    logic [7:0] data_byte;
    logic       last;
    logic [1:0] error;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic signed [7:0] level;
    logic [8:0]        frames;
    logic [7:0]        steps;
    logic [7:0]        dmag;
    logic              dneg;
  } cmd_t;

  typedef struct packed {
    logic [8:0] pos;
    logic [7:0] data_byte;
    logic [1:0] error;
    logic       done;
  } event_t;

endpackage

[sv/ese_front.sv]
// Front stage: accepts input items and turns them into decoded commands.
// Depends on ese_pkg.
module ese_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ese_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ese_pkg::cmd_t     cmd_data
);

  logic          cmd_vld_r, cmd_vld_nxt;
  ese_pkg::cmd_t cmd_r, cmd_nxt;
  logic          known;
  logic [8:0]    diff;
  logic [8:0]    mag;

  assign in_ready  = !cmd_vld_r || cmd_ready;
  assign cmd_valid = cmd_vld_r;
  assign cmd_data  = cmd_r;

  always_comb begin
    diff = {in_data.sweep_end[7], in_data.sweep_end} - {in_data.level[7], in_data.level};
    mag  = diff[8] ? (9'd0 - diff) : diff;
    known = 1'b1;
    cmd_nxt.op     = ese_pkg::OP_BEGIN;
    cmd_nxt.level  = in_data.level;
    cmd_nxt.frames = {1'b0, in_data.hold_frames} + 9'd1;
    cmd_nxt.steps  = in_data.sweep_steps;
    cmd_nxt.dmag   = mag[7:0];
    cmd_nxt.dneg   = diff[8];
    case (in_data.kind)
      ese_pkg::KIND_BEGIN:   cmd_nxt.op = ese_pkg::OP_BEGIN;
      ese_pkg::KIND_VALUE:   cmd_nxt.op = ese_pkg::OP_VALUE;
      ese_pkg::KIND_HOLD:    cmd_nxt.op = ese_pkg::OP_HOLD;
      ese_pkg::KIND_SWEEP:   cmd_nxt.op = ese_pkg::OP_SWEEP;
      ese_pkg::KIND_LOOP:    cmd_nxt.op = ese_pkg::OP_LOOP;
      ese_pkg::KIND_RELEASE: cmd_nxt.op = ese_pkg::OP_RELEASE;
      ese_pkg::KIND_FINISH:  cmd_nxt.op = ese_pkg::OP_FINISH;
      default:               known = 1'b0;
    endcase
    cmd_vld_nxt = cmd_vld_r;
    if (in_valid && in_ready) begin
      cmd_vld_nxt = known;
    end else if (cmd_ready) begin
      cmd_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

[sv/ese_queue.sv]
// Short command queue between the front stage and the sequencer.
// Depends on ese_pkg.
module ese_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ese_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ese_pkg::cmd_t rd_data
);

  ese_pkg::cmd_t                 mem_r [ese_pkg::QUEUE_DEPTH];
  logic [ese_pkg::QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ese_pkg::QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ese_pkg::QUEUE_AW:0]    count_r, count_nxt;
  logic                          push, pop;

  assign wr_ready = count_r != (ese_pkg::QUEUE_AW + 1)'(ese_pkg::QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ese_pkg::QUEUE_AW'(ese_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ese_pkg::QUEUE_AW'(ese_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[sv/ese_engine.sv]
// Sequencer that carries out one command at a time and produces byte writes.
// Owns the encoder state, the run-length coder and the sweep divider and stepper.
// Depends on ese_pkg.
module ese_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  ese_pkg::cmd_t   cmd_data,
  output logic            ev_valid,
  input  logic            ev_ready,
  output ese_pkg::event_t ev
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_VAL    = 10'b0000000010,
    ST_HOLD   = 10'b0000000100,
    ST_MARK   = 10'b0000001000,
    ST_JUMP   = 10'b0000010000,
    ST_HDR    = 10'b0000100000,
    ST_SWDIV  = 10'b0001000000,
    ST_SWSTEP = 10'b0010000000,
    ST_SWLAST = 10'b0100000000,
    ST_END    = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  state_t            tgt;
  ese_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [8:0]        wp_r, wp_nxt;
  logic [15:0]       pend_r, pend_nxt;
  logic signed [7:0] prev_r, prev_nxt;
  logic              prev_vld_r, prev_vld_nxt;
  logic [8:0]        nmark_r, nmark_nxt;
  logic              nmark_vld_r, nmark_vld_nxt;
  logic [8:0]        rmark_r, rmark_nxt;
  logic              rmark_vld_r, rmark_vld_nxt;
  logic              in_rel_r, in_rel_nxt;
  logic [15:0]       run_r, run_nxt;
  logic [7:0]        num_r, num_nxt;
  logic [8:0]        rem_r, rem_nxt;
  logic [2:0]        div_cnt_r, div_cnt_nxt;
  logic [7:0]        q_r, q_nxt;
  logic [7:0]        racc_r, racc_nxt;
  logic [7:0]        i_r, i_nxt;
  logic signed [7:0] now_r, now_nxt;
  logic [7:0]        scnt_r, scnt_nxt;

  logic              adv;
  logic              wp_adv;
  logic              do_flush;
  logic [8:0]        add_n;
  logic [16:0]       psum;
  logic [8:0]        rem_sh;
  logic              ge;
  logic [9:0]        t_w;
  logic [7:0]        t8;
  logic [8:0]        rsum;
  logic              carry;
  logic [8:0]        q_sum;
  logic              use_rel;
  logic              mvld;
  logic [8:0]        mark;
  logic [8:0]        wm1;
  state_t            step_tgt;

  assign adv = !ev_valid || ev_ready;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    tgt           = ST_END;
    cmd_nxt       = cmd_r;
    wp_nxt        = wp_r;
    pend_nxt      = pend_r;
    prev_nxt      = prev_r;
    prev_vld_nxt  = prev_vld_r;
    nmark_nxt     = nmark_r;
    nmark_vld_nxt = nmark_vld_r;
    rmark_nxt     = rmark_r;
    rmark_vld_nxt = rmark_vld_r;
    in_rel_nxt    = in_rel_r;
    run_nxt       = run_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    q_nxt         = q_r;
    racc_nxt      = racc_r;
    i_nxt         = i_r;
    now_nxt       = now_r;
    scnt_nxt      = scnt_r;
    cmd_ready     = 1'b0;
    ev_valid      = 1'b0;
    ev.pos        = wp_r;
    ev.data_byte  = '0;
    ev.error      = ese_pkg::ERR_NONE;
    ev.done       = 1'b0;
    wp_adv        = 1'b0;
    do_flush      = 1'b0;

    add_n = (cmd_data.op == ese_pkg::OP_VALUE) ? 9'd1 : cmd_data.frames;
    psum  = {1'b0, pend_r} + {8'd0, add_n};

    rem_sh = {rem_r[7:0], num_r[7]};
    ge     = rem_sh >= {1'b0, cmd_r.steps};

    t_w   = {{2{cmd_r.level[7]}}, cmd_r.level} +
            (cmd_r.dneg ? (10'd0 - {2'b0, q_r}) : {2'b0, q_r});
    t8    = t_w[7:0];
    rsum  = {1'b0, racc_r} + {1'b0, rem_r[7:0]};
    carry = rsum >= {1'b0, cmd_r.steps};
    q_sum = {1'b0, q_r} + {1'b0, num_r} + {8'd0, carry};
    step_tgt = (i_r == cmd_r.steps - 8'd1) ? ST_SWLAST : ST_SWSTEP;

    use_rel = (cmd_r.op == ese_pkg::OP_FINISH) && in_rel_r;
    mvld    = use_rel ? rmark_vld_r : nmark_vld_r;
    mark    = use_rel ? rmark_r : nmark_r;
    wm1     = wp_r - 9'd1;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          cmd_nxt   = cmd_data;
          do_flush  = 1'b1;
          case (cmd_data.op)
            ese_pkg::OP_BEGIN: begin
              wp_nxt        = ese_pkg::POINTER_START;
              pend_nxt      = '0;
              prev_vld_nxt  = 1'b0;
              nmark_vld_nxt = 1'b0;
              rmark_vld_nxt = 1'b0;
              in_rel_nxt    = 1'b0;
              do_flush      = 1'b0;
              tgt           = ST_HDR;
            end
            ese_pkg::OP_VALUE: begin
              if (prev_vld_r && prev_r == cmd_data.level) begin
                pend_nxt = psum[16] ? ese_pkg::FRAMES_TOP : psum[15:0];
                do_flush = 1'b0;
                tgt      = ST_END;
              end else begin
                prev_nxt     = cmd_data.level;
                prev_vld_nxt = 1'b1;
                tgt          = ST_VAL;
              end
            end
            ese_pkg::OP_HOLD: begin
              pend_nxt = psum[16] ? ese_pkg::FRAMES_TOP : psum[15:0];
              do_flush = 1'b0;
              tgt      = ST_END;
            end
            ese_pkg::OP_SWEEP: begin
              num_nxt     = cmd_data.dmag;
              rem_nxt     = '0;
              div_cnt_nxt = '0;
              now_nxt     = '0;
              scnt_nxt    = '0;
              tgt         = (cmd_data.steps == 8'd0) ? ST_SWLAST : ST_SWDIV;
            end
            ese_pkg::OP_LOOP: begin
              prev_vld_nxt = 1'b0;
              tgt          = ST_MARK;
            end
            ese_pkg::OP_RELEASE, ese_pkg::OP_FINISH: begin
              prev_vld_nxt = 1'b0;
              tgt          = ST_JUMP;
            end
            default: begin
              do_flush = 1'b0;
              tgt      = ST_END;
            end
          endcase
          if (do_flush && pend_r != 16'd0) begin
            run_nxt   = pend_r - 16'd1;
            pend_nxt  = '0;
            ret_nxt   = tgt;
            state_nxt = ST_HOLD;
          end else begin
            state_nxt = tgt;
          end
        end
      end
      ST_HOLD: begin
        ev_valid = 1'b1;
        wp_adv   = 1'b1;
        if (run_r > 16'd15) begin
          ev.data_byte = ese_pkg::BYTE_HOLD_FULL;
          run_nxt      = run_r - 16'd16;
        end else begin
          ev.data_byte = ese_pkg::BYTE_HOLD | {4'd0, run_r[3:0]};
          state_nxt    = ret_r;
        end
      end
      ST_VAL: begin
        ev_valid     = 1'b1;
        wp_adv       = 1'b1;
        ev.data_byte = cmd_r.level & ese_pkg::BYTE_VALUE_MASK;
        state_nxt    = ST_END;
      end
      ST_MARK: begin
        if (!in_rel_r) begin
          nmark_nxt     = wp_r;
          nmark_vld_nxt = 1'b1;
        end else begin
          rmark_nxt     = wp_r;
          rmark_vld_nxt = 1'b1;
        end
        state_nxt = ST_END;
      end
      ST_JUMP: begin
        ev_valid = 1'b1;
        wp_adv   = 1'b1;
        if (!mvld) begin
          ev.data_byte = wm1[7:0] | ese_pkg::BYTE_JUMP;
        end else begin
          ev.data_byte = mark[7:0] | ese_pkg::BYTE_JUMP;
          ev.error     = (nmark_vld_r && wp_r == nmark_r) ? ese_pkg::ERR_LOOP_END :
                         ese_pkg::ERR_NONE;
        end
        state_nxt = (cmd_r.op == ese_pkg::OP_RELEASE) ? ST_HDR : ST_END;
      end
      ST_HDR: begin
        ev_valid     = 1'b1;
        ev.pos       = '0;
        ev.data_byte = (cmd_r.op == ese_pkg::OP_BEGIN) ? ese_pkg::BYTE_HEADER_BEGIN :
                       wp_r[7:0];
        if (cmd_r.op == ese_pkg::OP_RELEASE) begin
          in_rel_nxt = 1'b1;
        end
        state_nxt = ST_END;
      end
      ST_SWDIV: begin
        rem_nxt     = ge ? (rem_sh - {1'b0, cmd_r.steps}) : rem_sh;
        num_nxt     = {num_r[6:0], ge};
        div_cnt_nxt = div_cnt_r + 3'd1;
        if (div_cnt_r == 3'd7) begin
          q_nxt     = '0;
          racc_nxt  = '0;
          i_nxt     = '0;
          state_nxt = ST_SWSTEP;
        end
      end
      ST_SWSTEP: begin
        i_nxt     = i_r + 8'd1;
        q_nxt     = q_sum[7:0];
        racc_nxt  = carry ? 8'(rsum - {1'b0, cmd_r.steps}) : rsum[7:0];
        state_nxt = step_tgt;
        if (i_r == 8'd0) begin
          now_nxt  = t8;
          scnt_nxt = '0;
        end else if (t8 != now_r) begin
          ev_valid     = 1'b1;
          wp_adv       = 1'b1;
          ev.data_byte = now_r & ese_pkg::BYTE_VALUE_MASK;
          now_nxt      = t8;
          scnt_nxt     = '0;
          if (scnt_r != 8'd0) begin
            run_nxt   = {8'd0, scnt_r - 8'd1};
            ret_nxt   = step_tgt;
            state_nxt = ST_HOLD;
          end
        end else begin
          scnt_nxt = scnt_r + 8'd1;
        end
      end
      ST_SWLAST: begin
        ev_valid     = 1'b1;
        wp_adv       = 1'b1;
        ev.data_byte = now_r & ese_pkg::BYTE_VALUE_MASK;
        prev_nxt     = now_r;
        prev_vld_nxt = 1'b1;
        if (scnt_r != 8'd0) begin
          run_nxt   = {8'd0, scnt_r - 8'd1};
          ret_nxt   = ST_END;
          state_nxt = ST_HOLD;
        end else begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        ev_valid  = 1'b1;
        ev.pos    = '0;
        ev.done   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (wp_adv && wp_r != ese_pkg::POINTER_TOP) begin
      wp_nxt = wp_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_END;
      wp_r        <= ese_pkg::POINTER_START;
      pend_r      <= '0;
      prev_vld_r  <= 1'b0;
      nmark_vld_r <= 1'b0;
      rmark_vld_r <= 1'b0;
      in_rel_r    <= 1'b0;
    end else if (adv) begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      wp_r        <= wp_nxt;
      pend_r      <= pend_nxt;
      prev_vld_r  <= prev_vld_nxt;
      nmark_vld_r <= nmark_vld_nxt;
      rmark_vld_r <= rmark_vld_nxt;
      in_rel_r    <= in_rel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r     <= cmd_nxt;
      prev_r    <= prev_nxt;
      nmark_r   <= nmark_nxt;
      rmark_r   <= rmark_nxt;
      run_r     <= run_nxt;
      num_r     <= num_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_nxt;
      q_r       <= q_nxt;
      racc_r    <= racc_nxt;
      i_r       <= i_nxt;
      now_r     <= now_nxt;
      scnt_r    <= scnt_nxt;
    end
  end

`ifndef SYNTH
  // The write pointer starts at one and saturates, so it never reaches the header slot.
  a_wp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r != 9'd0)
    else $error("write pointer reached zero");

  // The running remainder of the sweep stepper stays below the step count.
  a_racc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWSTEP) |-> (racc_r < cmd_r.steps))
    else $error("sweep remainder out of range");
`endif

endmodule

[sv/ese_emit.sv]
// Result stage: applies the store-full and per-item result limits, marks the
// final result of each item and holds results in an output register.
// Depends on ese_pkg.
module ese_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ev_valid,
  output logic               ev_ready,
  input  ese_pkg::event_t    ev,
  output logic               out_valid,
  input  logic               out_ready,
  output ese_pkg::out_item_t out_data
);

  logic                      out_vld_r, out_vld_nxt;
  ese_pkg::out_item_t        out_r, out_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  ese_pkg::out_item_t        pend_r, pend_nxt;
  logic [ese_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      drop_r, drop_nxt;
  logic                      out_free;
  logic                      take;
  logic                      full;
  ese_pkg::out_item_t        res;

  assign out_free  = !out_vld_r || out_ready;
  assign ev_ready  = out_free;
  assign take      = ev_valid && out_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    cnt_nxt      = cnt_r;
    drop_nxt     = drop_r;
    full          = ev.pos >= ese_pkg::MAX_POS;
    res.position  = ev.pos[7:0];
    res.data_byte = ev.data_byte;
    res.last      = 1'b0;
    res.error     = full ? ese_pkg::ERR_FULL : ev.error;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (take) begin
      if (ev.done) begin
        if (pend_vld_r) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          out_vld_nxt  = 1'b1;
          pend_vld_nxt = 1'b0;
        end
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end else begin
        if (full) begin
          drop_nxt = 1'b1;
        end
        if (!full || !drop_r) begin
          if (cnt_r < ese_pkg::CNT_W'(ese_pkg::RESULT_CAP)) begin
            if (pend_vld_r) begin
              out_nxt     = pend_r;
              out_vld_nxt = 1'b1;
            end
            pend_nxt     = res;
            pend_vld_nxt = 1'b1;
            cnt_nxt      = cnt_r + 1'b1;
          end else begin
            pend_nxt.error = ese_pkg::ERR_FULL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
      drop_r     <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      cnt_r      <= cnt_nxt;
      drop_r     <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

`ifndef SYNTH
  // A held-back result is always counted against the current item.
  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (cnt_r != '0))
    else $error("held result without count");

  // The per-item result count never passes the limit.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ese_pkg::CNT_W'(ese_pkg::RESULT_CAP))
    else $error("result count above limit");
`endif

endmodule

[sv/envelope_sequence_encoder_top.sv]
// Top level of the envelope sequence encoder.
// Depends on ese_pkg, ese_front, ese_queue, ese_engine and ese_emit.
//
// The front stage takes one item per cycle into a four-entry command queue when
// the queue has room; the sequencer behind it handles one command at a time. A
// command passes through dispatch, its byte writes and wrap-up (hold bytes cover
// up to 16 frames each), and a loop mark records its position in a state of its
// own. A sweep first runs its divider and then steps, and a value byte written
// where the level changes shares the cycle of its step; a sweep of zero steps
// skips both. The result register delivers at most one result per cycle, and a
// stalled result side holds the sequencer. There is no clearing pass after reset.
module envelope_sequence_encoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ese_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ese_pkg::out_item_t out_data
);

  logic            f_valid, f_ready;
  ese_pkg::cmd_t   f_cmd;
  logic            q_valid, q_ready;
  ese_pkg::cmd_t   q_cmd;
  logic            ev_valid, ev_ready;
  ese_pkg::event_t ev;

  ese_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_cmd)
  );

  ese_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  ese_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_cmd),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev)
  );

  ese_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
